### design/ising_metropolis_site_update_defines.svh
// ----------------------------------------------------------------------------
// ising_metropolis_site_update_defines
// Assertion macros used by the site update top-level design file.
// ----------------------------------------------------------------------------
`ifndef ISING_METROPOLIS_SITE_UPDATE_DEFINES_SVH
`define ISING_METROPOLIS_SITE_UPDATE_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define IMSU_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication
`define IMSU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define IMSU_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define IMSU_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### design/imsu_pkg.sv
// ----------------------------------------------------------------------------
// imsu_pkg
// Types and fixed constants of the Ising site update block.
// ----------------------------------------------------------------------------
package imsu_pkg;

    localparam int unsigned RAND_W       = 16;
    localparam int unsigned COORD_W      = 4;
    localparam int unsigned OUT_ENERGY_W = 11;
    localparam int unsigned CFG_IDX_W    = 2;
    localparam int unsigned CFG_DATA_W   = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DE4 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DE8 = 2'd1;

    localparam logic [CFG_DATA_W-1:0] THR_RESET = 16'hFFFF;

    // number of neighbours agreeing with the site spin
    localparam logic [2:0] AGREE_DE4 = 3'd3;
    localparam logic [2:0] AGREE_DE8 = 3'd4;

    typedef struct packed {
        logic self_spin;
        logic up;
        logic down;
        logic left;
        logic right;
    } t_nbr;

    typedef struct packed {
        logic accept;
        logic first_row;
        logic first_col;
        logic last_col;
        logic last_site;
    } t_site_ctl;

endpackage

### design/imsu_lattice.sv
// ----------------------------------------------------------------------------
// imsu_lattice
// Spin memory with a lookahead line and an update history that deliver the
// site spin and its four wrapped neighbours every cycle.
// ----------------------------------------------------------------------------
module imsu_lattice #(
    parameter int unsigned SIDE = 16,
    localparam int unsigned SITES = SIDE * SIDE,
    localparam int unsigned AW = $clog2(SITES)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  imsu_pkg::t_site_ctl i_ctl,
    input  logic [AW-1:0]      i_cur_idx,
    input  logic [AW-1:0]      i_next_idx,
    input  logic               i_new_spin,
    output imsu_pkg::t_nbr     o_nbr
);
    import imsu_pkg::*;

    logic             r_mem [SITES];
    logic [SIDE-1:0]  r_ahead;   // sites cur .. cur+SIDE-1, not yet updated
    logic [SIDE-1:0]  r_hist;    // bit k: new spin of site cur-1-k
    logic             r_filled;
    logic             n_filled;
    logic             r_rda_data;
    logic             r_rdb_data;
    logic             r_rda_known;
    logic             r_rdb_known;

    logic [AW:0]      sum_a;
    logic             wrap_a;
    logic [AW-1:0]    addr_a;
    logic             near_b;
    logic [AW-1:0]    addr_b;
    logic             down_spin;
    logic             bottom_spin;

    // down neighbour of the next site, wrapping to the top row
    assign sum_a  = (AW+1)'(i_next_idx) + (AW+1)'(SIDE);
    assign wrap_a = (sum_a >= (AW+1)'(SITES));
    assign addr_a = wrap_a ? AW'(sum_a - (AW+1)'(SITES)) : AW'(sum_a);

    // up neighbour of a top-row site lives in the bottom row
    assign near_b = (i_next_idx < AW'(SIDE));
    assign addr_b = near_b ? AW'((AW+1)'(i_next_idx) + (AW+1)'(SITES - SIDE)) : '0;

    assign n_filled = r_filled | (i_ctl.accept & i_ctl.last_site);

    always_ff @(posedge i_clk) begin
        r_rda_data <= r_mem[addr_a];
        r_rdb_data <= r_mem[addr_b];
        if (i_ctl.accept) begin
            r_mem[i_cur_idx] <= i_new_spin;
        end
    end

    // never-written entries read as spin up during the first sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filled    <= 1'b0;
            r_rda_known <= 1'b0;
            r_rdb_known <= 1'b0;
            r_ahead     <= '1;
        end else begin
            r_filled    <= n_filled;
            r_rda_known <= n_filled | wrap_a;
            r_rdb_known <= n_filled;
            if (i_ctl.accept) begin
                r_ahead <= {down_spin, r_ahead[SIDE-1:1]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_hist <= {r_hist[SIDE-2:0], i_new_spin};
        end
    end

    assign down_spin   = r_rda_known ? r_rda_data : 1'b1;
    assign bottom_spin = r_rdb_known ? r_rdb_data : 1'b1;

    always_comb begin
        o_nbr.self_spin = r_ahead[0];
        o_nbr.down      = down_spin;
        o_nbr.up        = i_ctl.first_row ? bottom_spin : r_hist[SIDE-1];
        o_nbr.left      = i_ctl.first_col ? r_ahead[SIDE-1] : r_hist[0];
        o_nbr.right     = i_ctl.last_col ? r_hist[SIDE-2] : r_ahead[1];
    end

endmodule

### design/ising_metropolis_site_update.sv
// ----------------------------------------------------------------------------
// ising_metropolis_site_update
// Metropolis update of a periodic square Ising lattice, one site per request.
// ----------------------------------------------------------------------------
// Each input request carries one random word and updates the next site in
// row-major order. The result (site row and column, new spin, flip flag,
// lattice energy saturated to 11 bits, end-of-sweep mark) is held in the
// output register from the edge after the request is taken.
// Throughput is 1 site per cycle while the receiver does not stall. The rate is set by
// the spin memory: per site one read for the down neighbour and one for the
// bottom-row neighbour of a top-row site, with the other neighbours taken
// from a lookahead line and a history of freshly updated spins.
// Reset puts every spin up, the site pointer at zero and the energy at minus
// two times the site count; no clearing pass runs, the first sweep reads
// unwritten spins as up, so requests are taken from the first cycle.
// The thresholds for energy rises 4 and 8 sit at registers 0 and 1 of the
// configuration port, which is always ready; other indexes are ignored.
// While the receiver stalls a held result, the input is stalled too and the
// result stays unchanged.
// ----------------------------------------------------------------------------
`include "ising_metropolis_site_update_defines.svh"

module ising_metropolis_site_update #(
    parameter int unsigned LATTICE_SIDE = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [imsu_pkg::RAND_W-1:0]         i_random_value,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [imsu_pkg::COORD_W-1:0]        o_site_row,
    output logic [imsu_pkg::COORD_W-1:0]        o_site_col,
    output logic                                o_spin_up,
    output logic                                o_flipped,
    output logic signed [imsu_pkg::OUT_ENERGY_W-1:0] o_total_energy,
    output logic                                o_sweep_done,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [imsu_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [imsu_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import imsu_pkg::*;

    localparam int unsigned SITES    = LATTICE_SIDE * LATTICE_SIDE;
    localparam int unsigned AW       = $clog2(SITES);
    localparam int unsigned CW       = $clog2(LATTICE_SIDE);
    localparam int unsigned RW       = (CW > COORD_W) ? CW : COORD_W;
    localparam int unsigned ENERGY_W = $clog2(2 * SITES + 1) + 1;
    localparam int unsigned EXT_W    = (ENERGY_W > OUT_ENERGY_W) ? ENERGY_W : OUT_ENERGY_W;
    localparam int          ENERGY_RESET_I = -2 * int'(SITES);
    localparam logic signed [ENERGY_W-1:0] ENERGY_RESET = ENERGY_W'(ENERGY_RESET_I);
    localparam int          E_MIN_I = -(2 ** (OUT_ENERGY_W - 1));
    localparam int          E_MAX_I = (2 ** (OUT_ENERGY_W - 1)) - 1;
    localparam logic signed [EXT_W-1:0] E_MIN = EXT_W'(E_MIN_I);
    localparam logic signed [EXT_W-1:0] E_MAX = EXT_W'(E_MAX_I);

    logic [CFG_DATA_W-1:0]       r_thr_de4;
    logic [CFG_DATA_W-1:0]       r_thr_de8;

    logic [AW-1:0]               r_idx;
    logic [AW-1:0]               n_idx;
    logic [CW-1:0]               r_row;
    logic [CW-1:0]               n_row;
    logic [CW-1:0]               r_col;
    logic [CW-1:0]               n_col;
    logic signed [ENERGY_W-1:0]  r_energy;
    logic signed [ENERGY_W-1:0]  n_energy;

    logic                        accept;
    t_site_ctl                   site_ctl;
    t_nbr                        nbr;
    logic [2:0]                  agree;
    logic                        flip;
    logic                        new_spin;
    logic signed [5:0]           de;
    logic signed [EXT_W-1:0]     e_x;
    logic signed [EXT_W-1:0]     e_sat;
    logic [RW-1:0]               row_x;
    logic [RW-1:0]               col_x;

    logic                        r_out_valid;
    logic [COORD_W-1:0]          r_site_row;
    logic [COORD_W-1:0]          r_site_col;
    logic                        r_spin_up;
    logic                        r_flipped;
    logic signed [OUT_ENERGY_W-1:0] r_total_energy;
    logic                        r_sweep_done;

    // configuration
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr_de4 <= THR_RESET;
            r_thr_de8 <= THR_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_DE4: r_thr_de4 <= i_cfg_data;
                CFG_DE8: r_thr_de8 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // handshake
    assign o_stall = r_out_valid & i_stall;
    assign accept  = i_valid & ~o_stall;

    // site walk
    always_comb begin
        site_ctl.accept    = accept;
        site_ctl.first_row = (r_row == '0);
        site_ctl.first_col = (r_col == '0);
        site_ctl.last_col  = (r_col == CW'(LATTICE_SIDE - 1));
        site_ctl.last_site = site_ctl.last_col && (r_row == CW'(LATTICE_SIDE - 1));
    end

    always_comb begin
        n_idx = r_idx;
        n_row = r_row;
        n_col = r_col;
        if (accept) begin
            priority if (site_ctl.last_site) begin
                n_idx = '0;
                n_row = '0;
                n_col = '0;
            end else if (site_ctl.last_col) begin
                n_idx = r_idx + 1'b1;
                n_row = r_row + 1'b1;
                n_col = '0;
            end else begin
                n_idx = r_idx + 1'b1;
                n_col = r_col + 1'b1;
            end
        end
    end

    imsu_lattice #(
        .SIDE (LATTICE_SIDE)
    ) u_lattice (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (site_ctl),
        .i_cur_idx  (r_idx),
        .i_next_idx (n_idx),
        .i_new_spin (new_spin),
        .o_nbr      (nbr)
    );

    // dE = 4 * agree - 8
    assign agree = 3'(nbr.up ~^ nbr.self_spin) + 3'(nbr.down ~^ nbr.self_spin)
                 + 3'(nbr.left ~^ nbr.self_spin) + 3'(nbr.right ~^ nbr.self_spin);
    assign de    = $signed(6'({1'b0, agree, 2'b00}) - 6'd8);

    always_comb begin
        priority if (agree == AGREE_DE8) begin
            flip = (i_random_value < r_thr_de8);
        end else if (agree == AGREE_DE4) begin
            flip = (i_random_value < r_thr_de4);
        end else begin
            flip = 1'b1;
        end
    end

    assign new_spin = nbr.self_spin ^ flip;
    assign n_energy = (accept && flip) ? (r_energy + ENERGY_W'(de)) : r_energy;

    // clamp to the output field range
    assign e_x = EXT_W'(n_energy);
    always_comb begin
        priority if (e_x < E_MIN) begin
            e_sat = E_MIN;
        end else if (e_x > E_MAX) begin
            e_sat = E_MAX;
        end else begin
            e_sat = e_x;
        end
    end

    assign row_x = RW'(r_row);
    assign col_x = RW'(r_col);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_energy    <= ENERGY_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_idx    <= n_idx;
            r_row    <= n_row;
            r_col    <= n_col;
            r_energy <= n_energy;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_site_row     <= row_x[COORD_W-1:0];
            r_site_col     <= col_x[COORD_W-1:0];
            r_spin_up      <= new_spin;
            r_flipped      <= flip;
            r_total_energy <= e_sat[OUT_ENERGY_W-1:0];
            r_sweep_done   <= site_ctl.last_site;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_site_row     = r_site_row;
    assign o_site_col     = r_site_col;
    assign o_spin_up      = r_spin_up;
    assign o_flipped      = r_flipped;
    assign o_total_energy = r_total_energy;
    assign o_sweep_done   = r_sweep_done;

    `IMSU_ASSERT_NEXT(a_idx_wrap, i_clk, i_rst_n, accept && site_ctl.last_site, r_idx == '0)
    `IMSU_ASSERT_NEXT(a_idx_step, i_clk, i_rst_n, accept && !site_ctl.last_site, r_idx == AW'($past(r_idx) + 1'b1))
    `IMSU_ASSERT_SAME(a_origin, i_clk, i_rst_n, site_ctl.first_row && site_ctl.first_col, r_idx == '0)
    `IMSU_ASSERT_NEXT(a_energy_hold, i_clk, i_rst_n, !(accept && flip), r_energy == $past(r_energy))

endmodule

### verif/imsu_site_checker.sv
// ----------------------------------------------------------------------------
// imsu_site_checker
// Predicts and checks every result of the Ising Metropolis site update block.
// ----------------------------------------------------------------------------
// Watches the input, output and configuration channels. It keeps its own
// lattice, site pointer, running energy and thresholds. It computes the
// expected result of each accepted request, and compares each accepted result
// field by field with the oldest expected one. It reports the mismatch count
// and the number of results still outstanding.
// ----------------------------------------------------------------------------
module imsu_site_checker #(
    parameter int unsigned SIDE = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    input  logic                                   i_in_stall,
    input  logic [imsu_pkg::RAND_W-1:0]            i_random_value,
    input  logic                                   i_out_valid,
    input  logic                                   i_out_stall,
    input  logic [imsu_pkg::COORD_W-1:0]           i_site_row,
    input  logic [imsu_pkg::COORD_W-1:0]           i_site_col,
    input  logic                                   i_spin_up,
    input  logic                                   i_flipped,
    input  logic signed [imsu_pkg::OUT_ENERGY_W-1:0] i_total_energy,
    input  logic                                   i_sweep_done,
    input  logic                                   i_cfg_valid,
    input  logic                                   i_cfg_ready,
    input  logic [imsu_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [imsu_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    output int                                     o_mismatches,
    output int                                     o_pending
);
    import imsu_pkg::*;

    localparam int unsigned SITES      = SIDE * SIDE;
    localparam int          ENERGY_LOW = -(1 << (OUT_ENERGY_W - 1));
    localparam int          ENERGY_TOP = (1 << (OUT_ENERGY_W - 1)) - 1;

    typedef struct packed {
        logic [COORD_W-1:0]             row;
        logic [COORD_W-1:0]             col;
        logic                           spin_up;
        logic                           flipped;
        logic signed [OUT_ENERGY_W-1:0] energy;
        logic                           sweep_done;
    } site_result_t;

    logic                  lattice [SITES];
    int unsigned           next_site;
    int                    lattice_energy;
    logic [CFG_DATA_W-1:0] thr_de4;
    logic [CFG_DATA_W-1:0] thr_de8;
    site_result_t          expected_sites [$];
    int                    mismatch_count = 0;

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
    end

    function automatic int spin_sign(input logic up);
        return up ? 1 : -1;
    endfunction

    // one Metropolis step on the local lattice, returns what the block must show
    function automatic site_result_t metropolis_update(input logic [RAND_W-1:0] rnd);
        site_result_t r;
        int unsigned  idx, row, col, up_r, down_r, left_c, right_c;
        int           nbr_sum, de, e_sat;
        logic         flip;
        idx     = (next_site >= SITES) ? 0 : next_site;
        row     = idx / SIDE;
        col     = idx % SIDE;
        up_r    = (row == 0) ? SIDE - 1 : row - 1;
        down_r  = (row + 1 == SIDE) ? 0 : row + 1;
        left_c  = (col == 0) ? SIDE - 1 : col - 1;
        right_c = (col + 1 == SIDE) ? 0 : col + 1;
        nbr_sum = spin_sign(lattice[up_r * SIDE + col]) + spin_sign(lattice[down_r * SIDE + col])
                + spin_sign(lattice[row * SIDE + left_c])
                + spin_sign(lattice[row * SIDE + right_c]);
        de = 2 * spin_sign(lattice[idx]) * nbr_sum;
        if (de <= 0) begin
            flip = 1'b1;
        end else if (de == 4) begin
            flip = (rnd < thr_de4);
        end else begin
            flip = (rnd < thr_de8);
        end
        if (flip) begin
            lattice[idx]   = ~lattice[idx];
            lattice_energy = lattice_energy + de;
        end
        e_sat = lattice_energy;
        if (e_sat < ENERGY_LOW) e_sat = ENERGY_LOW;
        if (e_sat > ENERGY_TOP) e_sat = ENERGY_TOP;
        r.row        = COORD_W'(row);
        r.col        = COORD_W'(col);
        r.spin_up    = lattice[idx];
        r.flipped    = flip;
        r.energy     = OUT_ENERGY_W'(e_sat);
        r.sweep_done = (idx + 1 == SITES);
        next_site    = r.sweep_done ? 0 : idx + 1;
        return r;
    endfunction

    always @(posedge i_clk) begin : monitor
        site_result_t want;
        site_result_t got;
        if (!i_rst_n) begin
            for (int k = 0; k < SITES; k++) lattice[k] = 1'b1;
            next_site      = 0;
            lattice_energy = -2 * int'(SITES);
            thr_de4        = THR_RESET;
            thr_de8        = THR_RESET;
            expected_sites.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                expected_sites.push_back(metropolis_update(i_random_value));
            end
            if (i_out_valid && !i_out_stall) begin
                got = '{i_site_row, i_site_col, i_spin_up, i_flipped, i_total_energy,
                        i_sweep_done};
                if (expected_sites.size() == 0) begin
                    if (mismatch_count < 10) begin
                        $display("unexpected result: site %0d,%0d spin %b flip %b energy %0d sweep %b",
                                 got.row, got.col, got.spin_up, got.flipped, got.energy,
                                 got.sweep_done);
                    end
                    mismatch_count++;
                end else begin
                    want = expected_sites.pop_front();
                    if (want !== got) begin
                        if (mismatch_count < 10) begin
                            $display("mismatch exp: site %0d,%0d spin %b flip %b energy %0d sweep %b",
                                     want.row, want.col, want.spin_up, want.flipped,
                                     want.energy, want.sweep_done);
                            $display("         got: site %0d,%0d spin %b flip %b energy %0d sweep %b",
                                     got.row, got.col, got.spin_up, got.flipped, got.energy,
                                     got.sweep_done);
                        end
                        mismatch_count++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_DE4: thr_de4 = i_cfg_data;
                    CFG_DE8: thr_de8 = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_mismatches <= mismatch_count;
        o_pending    <= expected_sites.size();
    end

endmodule

### verif/tb_ising_metropolis_site_update.sv
// ----------------------------------------------------------------------------
// tb_ising_metropolis_site_update
// Stimulus and verdict for the Ising Metropolis site update block.
// ----------------------------------------------------------------------------
// A directed opening tries the random word extremes at the reset thresholds
// and at zero thresholds. Then random phases sweep the lattice repeatedly
// under several threshold settings, from never accepting a rise to accepting all but the top word.
// Requests come in bursts with random gaps. The receiver stalls at a rate that
// changes over time. Thresholds only change while the block is idle. The
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_ising_metropolis_site_update;
    import imsu_pkg::*;

    localparam int unsigned SIDE        = 16;
    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int unsigned PHASE_ITEMS = 165;

    // indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_B = 2'd3;

    logic                           i_clk;
    logic                           i_rst_n        = 1'b0;
    logic                           i_valid        = 1'b0;
    logic                           o_stall;
    logic [RAND_W-1:0]              i_random_value = '0;
    logic                           o_valid;
    logic                           i_stall        = 1'b0;
    logic [COORD_W-1:0]             o_site_row;
    logic [COORD_W-1:0]             o_site_col;
    logic                           o_spin_up;
    logic                           o_flipped;
    logic signed [OUT_ENERGY_W-1:0] o_total_energy;
    logic                           o_sweep_done;
    logic                           i_cfg_valid    = 1'b0;
    logic                           o_cfg_ready;
    logic [CFG_IDX_W-1:0]           i_cfg_index    = '0;
    logic [CFG_DATA_W-1:0]          i_cfg_data     = '0;

    int                    mismatches;
    int                    pending;
    int unsigned           cycle_count = 0;
    int unsigned           stall_pct   = 0;
    int unsigned           stall_left  = 0;
    logic [CFG_DATA_W-1:0] cur_de4     = THR_RESET;
    logic [CFG_DATA_W-1:0] cur_de8     = THR_RESET;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    ising_metropolis_site_update #(
        .LATTICE_SIDE(SIDE)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_random_value (i_random_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_site_row     (o_site_row),
        .o_site_col     (o_site_col),
        .o_spin_up      (o_spin_up),
        .o_flipped      (o_flipped),
        .o_total_energy (o_total_energy),
        .o_sweep_done   (o_sweep_done),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    imsu_site_checker #(
        .SIDE(SIDE)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_stall     (o_stall),
        .i_random_value (i_random_value),
        .i_out_valid    (o_valid),
        .i_out_stall    (i_stall),
        .i_site_row     (o_site_row),
        .i_site_col     (o_site_col),
        .i_spin_up      (o_spin_up),
        .i_flipped      (o_flipped),
        .i_total_energy (o_total_energy),
        .i_sweep_done   (o_sweep_done),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_mismatches   (mismatches),
        .o_pending      (pending)
    );

    // receiver back-pressure: rate changes at random intervals, zero included
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            case ($urandom_range(4))
                0, 1:    stall_pct <= 0;
                2:       stall_pct <= 15;
                3:       stall_pct <= 40;
                default: stall_pct <= 75;
            endcase
            stall_left <= $urandom_range(300, 40);
        end else begin
            stall_left <= stall_left - 1;
        end
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_site(input logic [RAND_W-1:0] rnd);
        i_valid        <= 1'b1;
        i_random_value <= rnd;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic pause_input(input int unsigned n);
        if (n > 0) begin
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // leaves valid high so that back-to-back writes need no extra step
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic set_thresholds(input logic [CFG_DATA_W-1:0] d4, input logic [CFG_DATA_W-1:0] d8);
        if ($urandom_range(1)) write_reg(CFG_UNUSED_A, CFG_DATA_W'($urandom));
        write_reg(CFG_DE4, d4);
        if ($urandom_range(1)) write_reg(CFG_UNUSED_B, CFG_DATA_W'($urandom));
        write_reg(CFG_DE8, d8);
        i_cfg_valid <= 1'b0;
        cur_de4 = d4;
        cur_de8 = d8;
    endtask

    // mostly uniform words, with extremes and words right at the thresholds
    function automatic logic [RAND_W-1:0] pick_word();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return cur_de4 + RAND_W'($urandom_range(2)) - 1'b1;
            3:       return cur_de8 + RAND_W'($urandom_range(2)) - 1'b1;
            default: return RAND_W'($urandom_range(65535));
        endcase
    endfunction

    task automatic run_phase(input int unsigned n);
        int unsigned sent;
        int unsigned burst;
        sent = 0;
        while (sent < n) begin
            burst = $urandom_range(40, 1);
            for (int k = 0; k < burst && sent < n; k++) begin
                send_site(pick_word());
                sent++;
            end
            if ($urandom_range(3) != 0) pause_input($urandom_range(8, 1));
        end
    endtask

    logic [RAND_W-1:0] opening [12] = '{16'hFFFF, 16'h0000, 16'hFFFE, 16'h0001,
                                        16'h8000, 16'h7FFF, 16'hAAAA, 16'h5555,
                                        16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF};
    logic [CFG_DATA_W-1:0] phase_de4 [10] = '{16'hFFFF, 16'd0, 16'd11245, 16'd1200, 16'd29443,
                                              16'hFFFF, 16'd0, 16'd1, 16'd32768, 16'd0};
    logic [CFG_DATA_W-1:0] phase_de8 [10] = '{16'hFFFF, 16'd0, 16'd1930, 16'd22, 16'd13227,
                                              16'd0, 16'hFFFF, 16'd1, 16'd16384, 16'd0};

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset thresholds: all-up lattice, first rises tried at both word extremes
        foreach (opening[k]) begin
            send_site(opening[k]);
            if (k % 4 == 3) pause_input(2);
        end
        wait_idle();

        // zero thresholds never accept a rise, whatever the word
        set_thresholds('0, '0);
        foreach (opening[k]) send_site(~opening[k]);
        wait_idle();

        for (int p = 0; p < 10; p++) begin
            if (p == 9) begin
                set_thresholds(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
            end else begin
                set_thresholds(phase_de4[p], phase_de8[p]);
            end
            run_phase(PHASE_ITEMS);
            wait_idle();
        end

        if (mismatches == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
